/* hw/rtl/color_palette_entry_generator_macros.svh */
// Assertion helpers for the palette generator
`ifndef COLOR_PALETTE_ENTRY_GENERATOR_MACROS_SVH
`define COLOR_PALETTE_ENTRY_GENERATOR_MACROS_SVH

// same-cycle implication
`define CPEG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CPEG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/cpeg_pkg.sv */
package cpeg_pkg;

    localparam int unsigned MAX_PALETTE = 4096;
    localparam int unsigned SIZE_W      = 13;
    localparam int unsigned INDEX_W     = 12;
    localparam int unsigned LEVEL_W     = 16;
    localparam int unsigned SCHEME_W    = 5;
    localparam int unsigned DIVIDEND_W  = 32;
    localparam int unsigned QUOT_W      = 19;  // hue tops out at 6 sixths
    localparam int unsigned DIVISOR_W   = 16;  // 10 * n
    localparam int unsigned CFG_IDX_W   = 2;

    localparam logic [LEVEL_W-1:0] FULL_LEVEL = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] REG_PALETTE_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_SCHEME = 2'd1;

    localparam logic [SIZE_W-1:0]   RESET_PALETTE_SIZE = 13'd256;

    localparam logic [SCHEME_W-1:0] SCH_RED_TO_BLUE     = 5'd0;
    localparam logic [SCHEME_W-1:0] SCH_BLUE_TO_RED     = 5'd1;
    localparam logic [SCHEME_W-1:0] SCH_HSV             = 5'd2;
    localparam logic [SCHEME_W-1:0] SCH_RED             = 5'd3;
    localparam logic [SCHEME_W-1:0] SCH_GREEN           = 5'd4;
    localparam logic [SCHEME_W-1:0] SCH_BLUE            = 5'd5;
    localparam logic [SCHEME_W-1:0] SCH_YELLOW_TO_CYAN  = 5'd6;
    localparam logic [SCHEME_W-1:0] SCH_CYAN_TO_YELLOW  = 5'd7;
    localparam logic [SCHEME_W-1:0] SCH_RED_TO_YELLOW   = 5'd8;
    localparam logic [SCHEME_W-1:0] SCH_YELLOW_TO_RED   = 5'd9;
    localparam logic [SCHEME_W-1:0] SCH_YELLOW_TO_GREEN = 5'd10;
    localparam logic [SCHEME_W-1:0] SCH_GREEN_TO_YELLOW = 5'd11;
    localparam logic [SCHEME_W-1:0] SCH_GREEN_TO_CYAN   = 5'd12;
    localparam logic [SCHEME_W-1:0] SCH_CYAN_TO_GREEN   = 5'd13;
    localparam logic [SCHEME_W-1:0] SCH_CYAN_TO_BLUE    = 5'd14;
    localparam logic [SCHEME_W-1:0] SCH_BLUE_TO_CYAN    = 5'd15;
    localparam logic [SCHEME_W-1:0] SCH_BLUE_INV        = 5'd16;
    localparam logic [SCHEME_W-1:0] SCH_GREEN_INV       = 5'd17;
    localparam logic [SCHEME_W-1:0] SCH_RED_INV         = 5'd18;
    localparam logic [SCHEME_W-1:0] SCH_CUSTOM          = 5'd19;

    typedef struct packed {
        logic [SCHEME_W-1:0] scheme;
        logic                blank;   // custom scheme or index past the end
        logic                upper;   // second part of a two-part scheme
    } t_meta;

endpackage

/* hw/rtl/color_palette_entry_generator.sv */
// Pipeline: 1 setup stage, 19 divide stages and an output register.
// Throughput: one entry per cycle; a stalled output freezes the whole pipe.
// The divide is restoring long division, one quotient bit per stage.
// Reset (synchronous, active low) clears all valid bits and sets
// palette_size = 256, color_scheme = hsv. The config port is always ready.
`include "color_palette_entry_generator_macros.svh"

module color_palette_entry_generator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [cpeg_pkg::INDEX_W-1:0]        i_entry_index,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [cpeg_pkg::LEVEL_W-1:0]        o_red_level,
    output logic [cpeg_pkg::LEVEL_W-1:0]        o_green_level,
    output logic [cpeg_pkg::LEVEL_W-1:0]        o_blue_level,
    output logic                                o_in_range,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [cpeg_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [cpeg_pkg::SIZE_W-1:0]         i_cfg_data
);

    localparam int unsigned NS = cpeg_pkg::QUOT_W;

    logic [cpeg_pkg::SIZE_W-1:0]   r_palette_size;
    logic [cpeg_pkg::SCHEME_W-1:0] r_color_scheme;

    logic                                r_vld [0:NS];
    logic [cpeg_pkg::DIVISOR_W-1:0]      r_rem [0:NS];
    logic [cpeg_pkg::QUOT_W-1:0]         r_nq  [0:NS];
    logic [cpeg_pkg::DIVISOR_W-1:0]      r_den [0:NS];
    cpeg_pkg::t_meta                     r_meta[0:NS];

    logic                                r_out_vld;
    logic [cpeg_pkg::LEVEL_W-1:0]        r_red, r_green, r_blue;
    logic                                r_in_range;

    logic en;
    assign en          = !r_out_vld || i_out_ready;
    assign o_in_ready  = en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_palette_size <= cpeg_pkg::RESET_PALETTE_SIZE;
            r_color_scheme <= cpeg_pkg::SCH_HSV;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == cpeg_pkg::REG_PALETTE_SIZE) begin
                r_palette_size <= i_cfg_data;
            end else if (i_cfg_index == cpeg_pkg::REG_COLOR_SCHEME) begin
                r_color_scheme <= i_cfg_data[cpeg_pkg::SCHEME_W-1:0];
            end
        end
    end

    // ---------------- setup: numerator and denominator ----------------
    logic [12:0] n_size, n_half, n_first, n_j, n_d, n_i;
    logic        n_inv, n_upper, n_blank, n_hue;
    logic [15:0] n_ten_n, n_lnum, n_ldiv;
    logic [14:0] n_hnum;
    logic [31:0] n_dividend;
    logic [15:0] n_divisor;
    cpeg_pkg::t_meta n_meta;

    always_comb begin
        if (r_palette_size < 13'd2) begin
            n_size = 13'd2;
        end else if (r_palette_size > 13'(cpeg_pkg::MAX_PALETTE)) begin
            n_size = 13'(cpeg_pkg::MAX_PALETTE);
        end else begin
            n_size = r_palette_size;
        end
        n_i     = {1'b0, i_entry_index};
        n_half  = n_size >> 1;
        n_inv   = (r_color_scheme == cpeg_pkg::SCH_BLUE_INV)  ||
                  (r_color_scheme == cpeg_pkg::SCH_GREEN_INV) ||
                  (r_color_scheme == cpeg_pkg::SCH_RED_INV);
        n_first = n_inv ? (n_size - n_half) : n_half;
        n_upper = (n_i >= n_first);
        n_j     = n_upper ? (n_i - n_first) : 13'd0;
        n_d     = n_size - 13'd1;
        n_blank = (r_color_scheme == cpeg_pkg::SCH_CUSTOM) || (n_i >= n_size);
        n_ten_n = {n_size, 3'b000} + {2'b00, n_size, 1'b0};
        n_hue   = 1'b0;
        n_hnum  = 15'd0;
        n_lnum  = 16'd0;
        n_ldiv  = n_ten_n;
        unique case (r_color_scheme)
            cpeg_pkg::SCH_RED_TO_BLUE: begin
                n_hue  = 1'b1;
                n_hnum = {n_i[12:0], 2'b00};
            end
            cpeg_pkg::SCH_BLUE_TO_RED: begin
                n_hue  = 1'b1;
                n_hnum = {n_d, 2'b00} - {n_i, 2'b00};
            end
            cpeg_pkg::SCH_YELLOW_TO_CYAN: begin
                n_hue  = 1'b1;
                n_hnum = {2'b00, n_d} + {1'b0, n_i, 1'b0};
            end
            cpeg_pkg::SCH_CYAN_TO_YELLOW: begin
                n_hue  = 1'b1;
                n_hnum = {1'b0, n_d, 1'b0} + {2'b00, n_d} - {1'b0, n_i, 1'b0};
            end
            cpeg_pkg::SCH_RED_TO_YELLOW, cpeg_pkg::SCH_GREEN_TO_YELLOW,
            cpeg_pkg::SCH_GREEN_TO_CYAN, cpeg_pkg::SCH_BLUE_TO_CYAN: begin
                n_lnum = {3'b000, n_i};
                n_ldiv = {3'b000, n_size};
            end
            cpeg_pkg::SCH_YELLOW_TO_RED, cpeg_pkg::SCH_YELLOW_TO_GREEN,
            cpeg_pkg::SCH_CYAN_TO_GREEN, cpeg_pkg::SCH_CYAN_TO_BLUE: begin
                n_lnum = {3'b000, n_size - n_i};
                n_ldiv = {3'b000, n_size};
            end
            cpeg_pkg::SCH_RED, cpeg_pkg::SCH_GREEN, cpeg_pkg::SCH_BLUE: begin
                // 0.3 + 1.4 i/n, then 1.4 j/n
                if (!n_upper) begin
                    n_lnum = ({1'b0, n_size, 2'b00} - {3'b000, n_size})
                           + ({n_i[11:0], 4'b0000} - {2'b00, n_i, 1'b0});
                end else begin
                    n_lnum = {n_j[11:0], 4'b0000} - {2'b00, n_j, 1'b0};
                end
            end
            cpeg_pkg::SCH_BLUE_INV, cpeg_pkg::SCH_GREEN_INV, cpeg_pkg::SCH_RED_INV: begin
                // 0.7 - 1.4 i/n, then 1 - 1.4 j/n
                if (!n_upper) begin
                    n_lnum = ({n_size[12:0], 3'b000} - {3'b000, n_size})
                           - ({n_i[11:0], 4'b0000} - {2'b00, n_i, 1'b0});
                end else begin
                    n_lnum = n_ten_n - ({n_j[11:0], 4'b0000} - {2'b00, n_j, 1'b0});
                end
            end
            default: begin
                n_hue  = 1'b1;
                n_hnum = {n_i, 2'b00} + {1'b0, n_i, 1'b0};
            end
        endcase
        if (n_hue) begin
            n_dividend = {1'b0, n_hnum, 16'h0000};
            n_divisor  = {3'b000, n_d};
        end else begin
            n_dividend = {n_lnum, 16'h0000} - {16'h0000, n_lnum};
            n_divisor  = n_ldiv;
        end
        n_meta.scheme = r_color_scheme;
        n_meta.blank  = n_blank;
        n_meta.upper  = n_upper;
    end

    // ---------------- divide pipe ----------------
    logic [16:0] n_trial [1:NS];
    logic        n_qbit  [1:NS];

    always_comb begin
        for (int k = 1; k <= NS; k++) begin
            n_trial[k] = {r_rem[k-1], r_nq[k-1][NS-1]};
            n_qbit[k]  = (n_trial[k] >= {1'b0, r_den[k-1]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NS; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_in_valid;
            for (int k = 1; k <= NS; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rem[0]  <= {3'b000, n_dividend[31:NS]};
            r_nq[0]   <= n_dividend[NS-1:0];
            r_den[0]  <= n_divisor;
            r_meta[0] <= n_meta;
            for (int k = 1; k <= NS; k++) begin
                r_rem[k]  <= n_qbit[k] ? 16'(n_trial[k] - {1'b0, r_den[k-1]})
                                       : n_trial[k][15:0];
                r_nq[k]   <= {r_nq[k-1][NS-2:0], n_qbit[k]};
                r_den[k]  <= r_den[k-1];
                r_meta[k] <= r_meta[k-1];
            end
        end
    end

    // ---------------- color mapping ----------------
    logic [15:0] n_q, n_f, n_z, n_y, n_r, n_g, n_b;
    logic [2:0]  n_sector;
    cpeg_pkg::t_meta n_fm;

    always_comb begin
        n_fm     = r_meta[NS];
        n_q      = r_nq[NS][15:0];
        n_f      = n_q;
        n_z      = (n_f == 16'd0) ? 16'd0 : (n_f - 16'd1);
        n_y      = ~n_f;
        n_sector = (r_nq[NS][18:16] == 3'd6) ? 3'd0 : r_nq[NS][18:16];
        n_r      = 16'd0;
        n_g      = 16'd0;
        n_b      = 16'd0;
        unique case (n_fm.scheme)
            cpeg_pkg::SCH_RED_TO_YELLOW, cpeg_pkg::SCH_YELLOW_TO_RED: begin
                n_r = cpeg_pkg::FULL_LEVEL;
                n_g = n_q;
            end
            cpeg_pkg::SCH_YELLOW_TO_GREEN, cpeg_pkg::SCH_GREEN_TO_YELLOW: begin
                n_r = n_q;
                n_g = cpeg_pkg::FULL_LEVEL;
            end
            cpeg_pkg::SCH_GREEN_TO_CYAN, cpeg_pkg::SCH_CYAN_TO_GREEN: begin
                n_g = cpeg_pkg::FULL_LEVEL;
                n_b = n_q;
            end
            cpeg_pkg::SCH_CYAN_TO_BLUE, cpeg_pkg::SCH_BLUE_TO_CYAN: begin
                n_g = n_q;
                n_b = cpeg_pkg::FULL_LEVEL;
            end
            cpeg_pkg::SCH_RED: begin
                n_r = n_fm.upper ? cpeg_pkg::FULL_LEVEL : n_q;
                n_g = n_fm.upper ? n_q : 16'd0;
                n_b = n_g;
            end
            cpeg_pkg::SCH_GREEN: begin
                n_g = n_fm.upper ? cpeg_pkg::FULL_LEVEL : n_q;
                n_r = n_fm.upper ? n_q : 16'd0;
                n_b = n_r;
            end
            cpeg_pkg::SCH_BLUE: begin
                n_b = n_fm.upper ? cpeg_pkg::FULL_LEVEL : n_q;
                n_r = n_fm.upper ? n_q : 16'd0;
                n_g = n_r;
            end
            cpeg_pkg::SCH_BLUE_INV: begin
                n_r = n_fm.upper ? 16'd0 : n_q;
                n_g = n_r;
                n_b = n_fm.upper ? n_q : cpeg_pkg::FULL_LEVEL;
            end
            cpeg_pkg::SCH_GREEN_INV: begin
                n_r = n_fm.upper ? 16'd0 : n_q;
                n_b = n_r;
                n_g = n_fm.upper ? n_q : cpeg_pkg::FULL_LEVEL;
            end
            cpeg_pkg::SCH_RED_INV: begin
                n_g = n_fm.upper ? 16'd0 : n_q;
                n_b = n_g;
                n_r = n_fm.upper ? n_q : cpeg_pkg::FULL_LEVEL;
            end
            default: begin
                // hue ramps: full saturation and value
                unique case (n_sector)
                    3'd0: begin n_r = cpeg_pkg::FULL_LEVEL; n_g = n_z; end
                    3'd1: begin n_r = n_y; n_g = cpeg_pkg::FULL_LEVEL; end
                    3'd2: begin n_g = cpeg_pkg::FULL_LEVEL; n_b = n_z; end
                    3'd3: begin n_g = n_y; n_b = cpeg_pkg::FULL_LEVEL; end
                    3'd4: begin n_r = n_z; n_b = cpeg_pkg::FULL_LEVEL; end
                    default: begin n_r = cpeg_pkg::FULL_LEVEL; n_b = n_y; end
                endcase
            end
        endcase
        if (n_fm.blank) begin
            n_r = 16'd0;
            n_g = 16'd0;
            n_b = 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_vld[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_red      <= n_r;
            r_green    <= n_g;
            r_blue     <= n_b;
            r_in_range <= !n_fm.blank;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_red_level   = r_red;
    assign o_green_level = r_green;
    assign o_blue_level  = r_blue;
    assign o_in_range    = r_in_range;

    `CPEG_ASSERT_NOW(a_stall_blocks_input, r_out_vld && !i_out_ready, !o_in_ready, "input taken during output stall")
    `CPEG_ASSERT_NEXT(a_accept_enters_pipe, i_in_valid && o_in_ready, r_vld[0], "accepted beat lost at entry")
    `CPEG_ASSERT_NEXT(a_tail_reaches_output, r_vld[NS] && en, r_out_vld, "beat lost at output register")
    `CPEG_ASSERT_NOW(a_blank_is_black, r_out_vld && !r_in_range, (r_red | r_green | r_blue) == 16'd0, "out-of-range entry not black")

endmodule

/* test/testbench.sv */
module testbench;

    localparam int LATENCY   = 20;
    localparam int CYCLE_CAP = 400000;
    localparam int HOLD_LEN  = 120;

    typedef struct packed {
        logic [cpeg_pkg::LEVEL_W-1:0] red;
        logic [cpeg_pkg::LEVEL_W-1:0] green;
        logic [cpeg_pkg::LEVEL_W-1:0] blue;
        logic                         in_range;
    } t_color;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic [cpeg_pkg::INDEX_W-1:0] i_entry_index = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic [cpeg_pkg::LEVEL_W-1:0] o_red_level, o_green_level, o_blue_level;
    logic o_in_range;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [cpeg_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [cpeg_pkg::SIZE_W-1:0] i_cfg_data = '0;

    color_palette_entry_generator dut (.*);

    always #4 i_clk = ~i_clk;

    // predictor copy of the registers
    logic [cpeg_pkg::SIZE_W-1:0]   cur_size = cpeg_pkg::RESET_PALETTE_SIZE;
    logic [cpeg_pkg::SCHEME_W-1:0] cur_scheme = cpeg_pkg::SCH_HSV;

    logic [cpeg_pkg::INDEX_W-1:0] index_queue[$];
    t_color                       color_queue[$];

    int  send_idle = 0;     // percent
    int  recv_stall = 0;    // percent
    int  hold_requests = 0; // long receiver holds asked for by the sequence
    int  hold_served = 0;
    int  hold_left = 0;     // cycles of forced receiver stall still to go
    int  errors = 0;
    int  cycles = 0;
    int  results_seen = 0;
    int  beats_sent = 0;
    bit  scheme_seen[32];

    function automatic logic [cpeg_pkg::LEVEL_W-1:0] ramp_level(longint unsigned num,
                                                               longint unsigned den);
        return cpeg_pkg::LEVEL_W'((num * 65535) / den);
    endfunction

    function automatic t_color hue_color(longint unsigned hue);
        longint unsigned sector, f, z, y;
        t_color c;
        sector = (hue >> 16) % 6;
        f = hue & 16'hFFFF;
        z = (f * 65535) >> 16;
        y = ((65536 - f) * 65535) >> 16;
        c.in_range = 1'b1;
        case (sector)
            0: begin
                c.red = cpeg_pkg::FULL_LEVEL; c.green = cpeg_pkg::LEVEL_W'(z); c.blue = '0;
            end
            1: begin
                c.red = cpeg_pkg::LEVEL_W'(y); c.green = cpeg_pkg::FULL_LEVEL; c.blue = '0;
            end
            2: begin
                c.red = '0; c.green = cpeg_pkg::FULL_LEVEL; c.blue = cpeg_pkg::LEVEL_W'(z);
            end
            3: begin
                c.red = '0; c.green = cpeg_pkg::LEVEL_W'(y); c.blue = cpeg_pkg::FULL_LEVEL;
            end
            4: begin
                c.red = cpeg_pkg::LEVEL_W'(z); c.green = '0; c.blue = cpeg_pkg::FULL_LEVEL;
            end
            default: begin
                c.red = cpeg_pkg::FULL_LEVEL; c.green = '0; c.blue = cpeg_pkg::LEVEL_W'(y);
            end
        endcase
        return c;
    endfunction

    function automatic longint unsigned hue_of(longint unsigned base, longint unsigned k,
                                               bit down, longint unsigned i,
                                               longint unsigned n);
        longint unsigned d, num;
        d = n - 1;
        num = down ? (base * d - k * i) : (base * d + k * i);
        return (num << 16) / d;
    endfunction

    function automatic t_color palette_color(logic [cpeg_pkg::INDEX_W-1:0] idx);
        longint unsigned i, n, first, j, lo, hi, a, c;
        t_color col;
        i = idx;
        n = cur_size;
        if (n < 2) n = 2;
        if (n > cpeg_pkg::MAX_PALETTE) n = cpeg_pkg::MAX_PALETTE;
        col = '0;
        if (cur_scheme == cpeg_pkg::SCH_CUSTOM || i >= n) return col;
        first = (cur_scheme >= cpeg_pkg::SCH_BLUE_INV && cur_scheme <= cpeg_pkg::SCH_RED_INV) ?
                n - n / 2 : n / 2;
        j = (i >= first) ? i - first : 0;
        lo = ramp_level(3 * n + 14 * i, 10 * n);
        hi = ramp_level(14 * j, 10 * n);
        col.in_range = 1'b1;
        case (cur_scheme)
            cpeg_pkg::SCH_RED_TO_BLUE:    col = hue_color(hue_of(0, 4, 0, i, n));
            cpeg_pkg::SCH_BLUE_TO_RED:    col = hue_color(hue_of(4, 4, 1, i, n));
            cpeg_pkg::SCH_YELLOW_TO_CYAN: col = hue_color(hue_of(1, 2, 0, i, n));
            cpeg_pkg::SCH_CYAN_TO_YELLOW: col = hue_color(hue_of(3, 2, 1, i, n));
            cpeg_pkg::SCH_RED_TO_YELLOW: begin
                col.red = cpeg_pkg::FULL_LEVEL; col.green = ramp_level(i, n);
            end
            cpeg_pkg::SCH_YELLOW_TO_RED: begin
                col.red = cpeg_pkg::FULL_LEVEL; col.green = ramp_level(n - i, n);
            end
            cpeg_pkg::SCH_YELLOW_TO_GREEN: begin
                col.red = ramp_level(n - i, n); col.green = cpeg_pkg::FULL_LEVEL;
            end
            cpeg_pkg::SCH_GREEN_TO_YELLOW: begin
                col.red = ramp_level(i, n); col.green = cpeg_pkg::FULL_LEVEL;
            end
            cpeg_pkg::SCH_GREEN_TO_CYAN: begin
                col.green = cpeg_pkg::FULL_LEVEL; col.blue = ramp_level(i, n);
            end
            cpeg_pkg::SCH_CYAN_TO_GREEN: begin
                col.green = cpeg_pkg::FULL_LEVEL; col.blue = ramp_level(n - i, n);
            end
            cpeg_pkg::SCH_CYAN_TO_BLUE: begin
                col.green = ramp_level(n - i, n); col.blue = cpeg_pkg::FULL_LEVEL;
            end
            cpeg_pkg::SCH_BLUE_TO_CYAN: begin
                col.green = ramp_level(i, n); col.blue = cpeg_pkg::FULL_LEVEL;
            end
            cpeg_pkg::SCH_RED: begin
                if (i < first) col.red = cpeg_pkg::LEVEL_W'(lo);
                else begin
                    col.red = cpeg_pkg::FULL_LEVEL;
                    col.green = cpeg_pkg::LEVEL_W'(hi);
                    col.blue = cpeg_pkg::LEVEL_W'(hi);
                end
            end
            cpeg_pkg::SCH_GREEN: begin
                if (i < first) col.green = cpeg_pkg::LEVEL_W'(lo);
                else begin
                    col.red = cpeg_pkg::LEVEL_W'(hi);
                    col.green = cpeg_pkg::FULL_LEVEL;
                    col.blue = cpeg_pkg::LEVEL_W'(hi);
                end
            end
            cpeg_pkg::SCH_BLUE: begin
                if (i < first) col.blue = cpeg_pkg::LEVEL_W'(lo);
                else begin
                    col.red = cpeg_pkg::LEVEL_W'(hi);
                    col.green = cpeg_pkg::LEVEL_W'(hi);
                    col.blue = cpeg_pkg::FULL_LEVEL;
                end
            end
            cpeg_pkg::SCH_BLUE_INV, cpeg_pkg::SCH_GREEN_INV, cpeg_pkg::SCH_RED_INV: begin
                if (i < first) begin
                    a = ramp_level(7 * n - 14 * i, 10 * n);
                    c = cpeg_pkg::FULL_LEVEL;
                end else begin
                    a = 0;
                    c = ramp_level(10 * n - 14 * j, 10 * n);
                end
                if (cur_scheme == cpeg_pkg::SCH_BLUE_INV) begin
                    col.red = cpeg_pkg::LEVEL_W'(a);
                    col.green = cpeg_pkg::LEVEL_W'(a);
                    col.blue = cpeg_pkg::LEVEL_W'(c);
                end else if (cur_scheme == cpeg_pkg::SCH_GREEN_INV) begin
                    col.red = cpeg_pkg::LEVEL_W'(a);
                    col.green = cpeg_pkg::LEVEL_W'(c);
                    col.blue = cpeg_pkg::LEVEL_W'(a);
                end else begin
                    col.red = cpeg_pkg::LEVEL_W'(c);
                    col.green = cpeg_pkg::LEVEL_W'(a);
                    col.blue = cpeg_pkg::LEVEL_W'(a);
                end
            end
            default: col = hue_color(hue_of(0, 6, 0, i, n));
        endcase
        return col;
    endfunction

    // driver
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                color_queue = {color_queue, palette_color(i_entry_index)};
                beats_sent <= beats_sent + 1;
            end
            if (!i_in_valid || o_in_ready) begin
                if (index_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
                    i_entry_index <= index_queue.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver ready, with long holds counted here
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (hold_requests != hold_served) begin
                hold_served <= hold_served + 1;
                hold_left <= HOLD_LEN;
                i_out_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall);
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_color want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                results_seen <= results_seen + 1;
                if (color_queue.size() == 0) begin
                    $error("result beat with nothing expected");
                    errors = errors + 1;
                end else begin
                    want = color_queue.pop_front();
                    if (o_red_level !== want.red) begin
                        $error("red_level: expected %0d, got %0d", want.red, o_red_level);
                        errors = errors + 1;
                    end
                    if (o_green_level !== want.green) begin
                        $error("green_level: expected %0d, got %0d", want.green,
                               o_green_level);
                        errors = errors + 1;
                    end
                    if (o_blue_level !== want.blue) begin
                        $error("blue_level: expected %0d, got %0d", want.blue,
                               o_blue_level);
                        errors = errors + 1;
                    end
                    if (o_in_range !== want.in_range) begin
                        $error("in_range: expected %0d, got %0d", want.in_range,
                               o_in_range);
                        errors = errors + 1;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycles);
            $display("color_palette_entry_generator regression: fail");
            $finish;
        end
    end

    task automatic wait_drained();
        while (index_queue.size() > 0 || i_in_valid || color_queue.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [cpeg_pkg::CFG_IDX_W-1:0] idx,
                             logic [cpeg_pkg::SIZE_W-1:0] data);
        i_cfg_index <= idx;
        i_cfg_data <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == cpeg_pkg::REG_PALETTE_SIZE) cur_size = data;
        else cur_scheme = data[cpeg_pkg::SCHEME_W-1:0];
        @(posedge i_clk);
    endtask

    // mostly in-palette indices, some past the end, a few raw
    function automatic logic [cpeg_pkg::INDEX_W-1:0] pick_index();
        int n, r;
        n = cur_size < 2 ? 2 :
            (cur_size > cpeg_pkg::MAX_PALETTE ? cpeg_pkg::MAX_PALETTE : cur_size);
        r = $urandom_range(99);
        if (r < 80) return cpeg_pkg::INDEX_W'($urandom_range(n - 1));
        if (r < 90)
            return cpeg_pkg::INDEX_W'($urandom_range(n - 1 + 3, n - 1 > 3 ? n - 3 : 0));
        return cpeg_pkg::INDEX_W'($urandom);
    endfunction

    initial begin
        int sizes[$];
        int sz, sch, phase, covered;
        sizes = '{0, 1, 2, 3, 7, 16, 255, 256, 1000, 4095, 4096, 4097, 8191};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values first: hsv over 256 entries, edges and wrap
        index_queue = '{0, 1, 127, 128, 254, 255, 256, 4095};
        wait_drained();
        scheme_seen[cpeg_pkg::SCH_HSV] = 1;

        // directed: every scheme on a small odd palette, extremes of index
        write_reg(cpeg_pkg::REG_PALETTE_SIZE, cpeg_pkg::SIZE_W'(7));
        for (sch = 0; sch < 32; sch++) begin
            write_reg(cpeg_pkg::REG_COLOR_SCHEME, cpeg_pkg::SIZE_W'(sch));
            scheme_seen[sch] = 1;
            index_queue = '{0, 3, 6, 7, 4095};
            wait_drained();
        end

        // random phases across sizes, schemes and idle mixes
        for (phase = 0; phase < 64; phase++) begin
            case (phase % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 74; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 74; end
                default: begin send_idle = 36; recv_stall = 36; end
            endcase
            sz = (phase < sizes.size()) ? sizes[phase] :
                 ($urandom_range(3) == 0 ? $urandom_range(8191) : $urandom_range(40));
            sch = $urandom_range(31);
            write_reg(cpeg_pkg::REG_PALETTE_SIZE, cpeg_pkg::SIZE_W'(sz));
            write_reg(cpeg_pkg::REG_COLOR_SCHEME, cpeg_pkg::SIZE_W'(sch));
            scheme_seen[sch] = 1;
            if (phase == 5) hold_requests++;
            repeat (22) index_queue = {index_queue, pick_index()};
            if (phase == 9) begin
                wait_drained();
                repeat (22) index_queue = {index_queue, pick_index()};
            end
            wait_drained();
        end
        send_idle = 0;
        recv_stall = 0;
        repeat (LATENCY * 2) @(posedge i_clk);

        covered = 0;
        for (sch = 0; sch < 32; sch++) if (scheme_seen[sch]) covered++;
        $display("sent %0d index beats, checked %0d color beats over %0d scheme codes",
                 beats_sent, results_seen, covered);
        $display("palette sizes from 0 to 8191, idle and stall mixes up to 74 percent");
        if (errors == 0 && color_queue.size() == 0)
            $display("color_palette_entry_generator regression: pass");
        else
            $display("color_palette_entry_generator regression: fail");
        $finish;
    end
endmodule
